// ----- src/pfmt_pkg.sv -----
package pfmt_pkg;

   localparam int FLAG_W = 7;
   localparam int KEY_WORD_W = 64;

   typedef enum logic [1:0] {
      MODE_APPLY  = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_FORMAT = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef struct packed {
      logic [FLAG_W-1:0] new_flags;
      logic              matched;
      logic              status;
   } result_type;

   typedef struct packed {
      logic [FLAG_W-1:0] set_mask;
      logic [FLAG_W-1:0] clear_mask;
      logic              permanent;
   } attr_type;

endpackage

// ----- src/pfmt_ram.sv -----
module pfmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/pfmt_ctrl.sv -----
module pfmt_ctrl #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_W = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  pfmt_pkg::mode_type                  start_mode,
   input  logic [pfmt_pkg::FLAG_W-1:0]         start_flags,
   input  logic                                rsp_free,
   input  logic [KEY_W-1:0]                    key_req,
   input  logic [KEY_W-1:0]                    key_rd,
   input  pfmt_pkg::attr_type                  attr_rd,
   output logic                                ready,
   output logic                                done,
   output pfmt_pkg::result_type                result,
   output logic                                rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
   output logic                                wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
   localparam logic [IW:0] COUNT_END = (IW + 1)'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_APPLY,
      S_INSERT,
      S_DONE
   } state_type;

   state_type                   state_ff;
   logic [TABLE_DEPTH-1:0]      active_ff;
   logic [TABLE_DEPTH-1:0]      end_ff;
   logic [IW:0]                 scan_ff;
   logic                        chk_valid_ff;
   logic [IW-1:0]               chk_idx_ff;
   logic [pfmt_pkg::FLAG_W-1:0] flags_ff;
   logic                        matched_ff;
   logic                        status_ff;

   logic [IW-1:0]               slot;
   logic                        hit;
   logic                        ins_write;
   logic [IW-1:0]               ins_addr;

   assign slot = scan_ff[IW-1:0];
   assign hit = active_ff[chk_idx_ff] && (key_rd == key_req);

   always_comb begin
      ins_write = 1'b0;
      ins_addr = slot;
      if (state_ff == S_INSERT) begin
         if (end_ff[slot]) begin
            if (!active_ff[slot]) begin
               ins_write = 1'b1;
            end else if (slot != LAST) begin
               ins_write = 1'b1;
               ins_addr = slot + 1'b1;
            end
         end else if (!active_ff[slot]) begin
            ins_write = 1'b1;
         end
      end
   end

   assign rd_en = (state_ff == S_APPLY) && (scan_ff < COUNT_END);
   assign rd_addr = slot;
   assign wr_en = ins_write;
   assign wr_addr = ins_addr;
   assign ready = (state_ff == S_IDLE);
   assign done = (state_ff == S_DONE);
   assign result.new_flags = flags_ff;
   assign result.matched = matched_ff;
   assign result.status = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= '0;
         end_ff <= TABLE_DEPTH'(1);
         scan_ff <= '0;
         chk_valid_ff <= 1'b0;
         chk_idx_ff <= '0;
         flags_ff <= '0;
         matched_ff <= 1'b0;
         status_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  flags_ff <= (start_mode == pfmt_pkg::MODE_APPLY) ? start_flags : '0;
                  matched_ff <= 1'b0;
                  status_ff <= 1'b0;
                  scan_ff <= '0;
                  chk_valid_ff <= 1'b0;
                  unique case (start_mode)
                     pfmt_pkg::MODE_APPLY: begin
                        state_ff <= S_APPLY;
                     end
                     pfmt_pkg::MODE_INSERT: begin
                        state_ff <= S_INSERT;
                     end
                     pfmt_pkg::MODE_FORMAT: begin
                        active_ff <= '0;
                        end_ff <= TABLE_DEPTH'(1);
                        state_ff <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_APPLY: begin
               if (rd_en) begin
                  scan_ff <= scan_ff + 1'b1;
               end
               chk_valid_ff <= rd_en;
               chk_idx_ff <= slot;
               if (chk_valid_ff) begin
                  if (hit) begin
                     flags_ff <= (flags_ff | attr_rd.set_mask) & ~attr_rd.clear_mask;
                     matched_ff <= 1'b1;
                     if (!attr_rd.permanent) begin
                        active_ff[chk_idx_ff] <= 1'b0;
                     end
                  end
                  if (end_ff[chk_idx_ff] || chk_idx_ff == LAST) begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_INSERT: begin
               if (ins_write) begin
                  active_ff[ins_addr] <= 1'b1;
                  if (ins_addr != slot) begin
                     end_ff <= (end_ff & ~(TABLE_DEPTH'(1) << slot))
                               | (TABLE_DEPTH'(1) << ins_addr);
                  end
                  state_ff <= S_DONE;
               end else if (end_ff[slot]) begin
                  status_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else if (slot == LAST) begin
                  state_ff <= S_DONE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- src/pending_flag_modifier_table.sv -----
// Channel   | Valid     | Stall     | Payload
// ----------+-----------+-----------+------------------------------------------------
// request   | req_valid | req_stall | req_mode, req_key_word_0..3, req_user_flags,
//           |           |           | req_set_mask, req_clear_mask, req_keep_after_use
// response  | rsp_valid | rsp_stall | rsp_new_flags, rsp_matched, rsp_status
//
// An apply transaction reads one slot per cycle from the registered key and mask memories
// and stops at the end mark or the last slot. An insert transaction scans the flags one slot
// per cycle. A format transaction, like reset, empties the table at once; no clearing pass.
// A new request is taken while a finished response still waits on rsp_stall, but the
// block holds req_stall high until that next result can enter the response register.
module pending_flag_modifier_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_WORDS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_mode,
   input  logic [pfmt_pkg::KEY_WORD_W-1:0]     req_key_word_0,
   input  logic [pfmt_pkg::KEY_WORD_W-1:0]     req_key_word_1,
   input  logic [pfmt_pkg::KEY_WORD_W-1:0]     req_key_word_2,
   input  logic [pfmt_pkg::KEY_WORD_W-1:0]     req_key_word_3,
   input  logic [pfmt_pkg::FLAG_W-1:0]         req_user_flags,
   input  logic [pfmt_pkg::FLAG_W-1:0]         req_set_mask,
   input  logic [pfmt_pkg::FLAG_W-1:0]         req_clear_mask,
   input  logic                                req_keep_after_use,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pfmt_pkg::FLAG_W-1:0]         rsp_new_flags,
   output logic                                rsp_matched,
   output logic                                rsp_status
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int KEY_W = KEY_WORDS * pfmt_pkg::KEY_WORD_W;
   localparam int FULL_KEY_W = 4 * pfmt_pkg::KEY_WORD_W;

   logic                        accept;
   logic                        ready;
   logic                        done;
   logic                        rsp_free;
   pfmt_pkg::result_type        result;
   logic [FULL_KEY_W-1:0]       key_full;

   logic [KEY_W-1:0]            key_ff;
   pfmt_pkg::attr_type          attr_ff;
   logic                        rsp_valid_ff;
   pfmt_pkg::result_type        rsp_ff;

   logic                        rd_en;
   logic [IW-1:0]               rd_addr;
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [KEY_W-1:0]            key_rd;
   pfmt_pkg::attr_type          attr_rd;

   assign key_full = {req_key_word_3, req_key_word_2, req_key_word_1, req_key_word_0};
   assign accept = req_valid && ready;
   assign req_stall = !ready;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= key_full[KEY_W-1:0];
         attr_ff.set_mask <= req_set_mask;
         attr_ff.clear_mask <= req_clear_mask;
         attr_ff.permanent <= req_keep_after_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done && rsp_free) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_new_flags = rsp_ff.new_flags;
   assign rsp_matched = rsp_ff.matched;
   assign rsp_status = rsp_ff.status;

   pfmt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   pfmt_ram #(
      .WIDTH ($bits(pfmt_pkg::attr_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (attr_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (attr_rd)
   );

   pfmt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_W       (KEY_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .start_mode  (pfmt_pkg::mode_type'(req_mode)),
      .start_flags (req_user_flags),
      .rsp_free    (rsp_free),
      .key_req     (key_ff),
      .key_rd      (key_rd),
      .attr_rd     (attr_rd),
      .ready       (ready),
      .done        (done),
      .result      (result),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr)
   );

endmodule

// ----- dv/pending_flag_modifier_table_tb.sv -----
`timescale 1ns / 100ps

module pending_flag_modifier_table_tb;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_WORDS = 4;
   localparam int FLAG_W = pfmt_pkg::FLAG_W;
   localparam int KEY_WORD_W = pfmt_pkg::KEY_WORD_W;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_SEGMENTS = 15;
   localparam int SEGMENT_ITEMS = 50;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      pfmt_pkg::mode_type mode;
      logic [3:0][63:0]   key;
      logic [FLAG_W-1:0]  user_flags;
      logic [FLAG_W-1:0]  set_mask;
      logic [FLAG_W-1:0]  clear_mask;
      logic               keep;
   } flag_request_type;

   class flag_table_shadow_type;
      logic [3:0][63:0]     keys [TABLE_DEPTH];
      logic [FLAG_W-1:0]    sets [TABLE_DEPTH];
      logic [FLAG_W-1:0]    clears [TABLE_DEPTH];
      bit                   active [TABLE_DEPTH];
      bit                   perm [TABLE_DEPTH];
      bit                   end_mark [TABLE_DEPTH];
      pfmt_pkg::result_type owed_results [$];
      int                   mismatches;
      int                   apply_hits;
      int                   full_drops;
      int                   formats;

      function new();
         mismatches = 0;
         apply_hits = 0;
         full_drops = 0;
         formats = 0;
         clear_all();
      endfunction

      function void wipe(int s);
         keys[s] = '0;
         sets[s] = '0;
         clears[s] = '0;
         active[s] = 1'b0;
         perm[s] = 1'b0;
      endfunction

      function void clear_all();
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            wipe(s);
            end_mark[s] = 1'b0;
         end
         end_mark[0] = 1'b1;
      endfunction

      function void store(int s, flag_request_type r);
         keys[s] = r.key;
         sets[s] = r.set_mask;
         clears[s] = r.clear_mask;
         active[s] = 1'b1;
         perm[s] = r.keep;
      endfunction

      function void absorb_request(flag_request_type r);
         pfmt_pkg::result_type res;
         logic [FLAG_W-1:0]    f;
         res = '0;
         case (r.mode)
            pfmt_pkg::MODE_APPLY: begin
               f = r.user_flags;
               for (int s = 0; s < TABLE_DEPTH; s++) begin
                  if (active[s] && keys[s] == r.key) begin
                     f = (f | sets[s]) & ~clears[s];
                     res.matched = 1'b1;
                     if (!perm[s]) wipe(s);
                  end
                  if (end_mark[s]) break;
               end
               res.new_flags = f;
               if (res.matched) apply_hits++;
            end
            pfmt_pkg::MODE_INSERT: begin
               for (int s = 0; s < TABLE_DEPTH; s++) begin
                  if (end_mark[s]) begin
                     if (active[s]) begin
                        if (s + 1 >= TABLE_DEPTH) begin
                           res.status = 1'b1;
                        end else begin
                           end_mark[s] = 1'b0;
                           store(s + 1, r);
                           end_mark[s + 1] = 1'b1;
                        end
                     end else begin
                        store(s, r);
                     end
                     break;
                  end
                  if (!active[s]) begin
                     store(s, r);
                     break;
                  end
               end
               if (res.status) full_drops++;
            end
            pfmt_pkg::MODE_FORMAT: begin
               clear_all();
               formats++;
            end
            default: begin
            end
         endcase
         owed_results.push_back(res);
      endfunction

      function void compare_response(pfmt_pkg::result_type got);
         pfmt_pkg::result_type want;
         if (owed_results.size() == 0) begin
            $error("Response with no transaction outstanding: %0h", got);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         if (got.new_flags !== want.new_flags) begin
            $error("new_flags: expected %0h, actual %0h", want.new_flags, got.new_flags);
            mismatches++;
         end
         if (got.matched !== want.matched) begin
            $error("matched: expected %0h, actual %0h", want.matched, got.matched);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0h, actual %0h", want.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_mode;
   logic [KEY_WORD_W-1:0] req_key_word_0;
   logic [KEY_WORD_W-1:0] req_key_word_1;
   logic [KEY_WORD_W-1:0] req_key_word_2;
   logic [KEY_WORD_W-1:0] req_key_word_3;
   logic [FLAG_W-1:0]     req_user_flags;
   logic [FLAG_W-1:0]     req_set_mask;
   logic [FLAG_W-1:0]     req_clear_mask;
   logic                  req_keep_after_use;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [FLAG_W-1:0]     rsp_new_flags;
   logic                  rsp_matched;
   logic                  rsp_status;

   flag_table_shadow_type shadow;
   logic [3:0][63:0]      key_pool [6];
   bit                    no_idle;
   int                    sent_count;
   int                    rsp_count;
   int                    cycle_count;

   pending_flag_modifier_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_WORDS(KEY_WORDS)
   ) DUT (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pending_flag_modifier_table_tb failed");
         $finish;
      end
   end

   function automatic logic [3:0][63:0] random_key();
      logic [3:0][63:0] k;
      for (int w = 0; w < 4; w++) k[w] = {$urandom, $urandom};
      return k;
   endfunction

   function automatic flag_request_type make_request(pfmt_pkg::mode_type mode,
                                                     logic [3:0][63:0] key,
                                                     logic [FLAG_W-1:0] flags,
                                                     logic [FLAG_W-1:0] set_bits,
                                                     logic [FLAG_W-1:0] clear_bits,
                                                     logic keep);
      flag_request_type r;
      r.mode = mode;
      r.key = key;
      r.user_flags = flags;
      r.set_mask = set_bits;
      r.clear_mask = clear_bits;
      r.keep = keep;
      return r;
   endfunction

   function automatic flag_request_type random_request(int insert_pct);
      flag_request_type r;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) r.mode = pfmt_pkg::MODE_INSERT;
      else if (pick < 96) r.mode = pfmt_pkg::MODE_APPLY;
      else if (pick < 99) r.mode = pfmt_pkg::MODE_FORMAT;
      else r.mode = pfmt_pkg::MODE_UNUSED;
      if ($urandom_range(0, 6) == 0) r.key = random_key();
      else r.key = key_pool[$urandom_range(0, 5)];
      r.user_flags = FLAG_W'($urandom_range(0, 127));
      r.set_mask = FLAG_W'($urandom_range(0, 127));
      r.clear_mask = FLAG_W'($urandom_range(0, 127));
      r.keep = ($urandom_range(0, 3) == 0);
      return r;
   endfunction

   task automatic push_request(input flag_request_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_key_word_0 <= r.key[0];
      req_key_word_1 <= r.key[1];
      req_key_word_2 <= r.key[2];
      req_key_word_3 <= r.key[3];
      req_user_flags <= r.user_flags;
      req_set_mask <= r.set_mask;
      req_clear_mask <= r.clear_mask;
      req_keep_after_use <= r.keep;
      do @(posedge clock); while (req_stall);
      shadow.absorb_request(r);
      sent_count++;
   endtask

   initial begin
      int                   hold;
      pfmt_pkg::result_type got;
      wait (reset == 1'b0);
      forever begin
         if (rsp_count == 100 || rsp_count == 500) hold = LONG_HOLD;
         else hold = no_idle ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         got.new_flags = rsp_new_flags;
         got.matched = rsp_matched;
         got.status = rsp_status;
         shadow.compare_response(got);
         rsp_count++;
      end
   end

   initial begin
      logic [3:0][63:0] key_a;
      logic [3:0][63:0] key_b;
      logic [3:0][63:0] key_c;
      logic [3:0][63:0] near;
      int               insert_pct;
      int               drain;

      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = pfmt_pkg::MODE_APPLY;
      req_key_word_0 = '0;
      req_key_word_1 = '0;
      req_key_word_2 = '0;
      req_key_word_3 = '0;
      req_user_flags = '0;
      req_set_mask = '0;
      req_clear_mask = '0;
      req_keep_after_use = 1'b0;
      rsp_stall = 1'b0;
      no_idle = 1'b0;
      sent_count = 0;
      rsp_count = 0;
      cycle_count = 0;
      shadow = new();

      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = random_key();
      key_pool[3] = key_pool[2];
      key_pool[3][1][$urandom_range(0, 63)] ^= 1'b1;
      key_pool[4] = random_key();
      key_pool[5] = random_key();

      key_a = random_key();
      key_b = key_a;
      key_b[3] = ~key_b[3];
      key_c = random_key();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty table: an all-zero key must not match inactive slots.
      push_request(make_request(pfmt_pkg::MODE_APPLY, '0, 7'h7f, 7'h00, 7'h00, 1'b0));
      push_request(make_request(pfmt_pkg::MODE_INSERT, key_a, 7'h00, 7'h7f, 7'h00, 1'b0));
      push_request(make_request(pfmt_pkg::MODE_INSERT, key_a, 7'h00, 7'h00, 7'h55, 1'b1));
      push_request(make_request(pfmt_pkg::MODE_INSERT, key_b, 7'h00, 7'h01, 7'h00, 1'b1));
      push_request(make_request(pfmt_pkg::MODE_APPLY, key_a, 7'h00, 7'h00, 7'h00, 1'b0));
      near = key_a;
      near[0][0] = ~near[0][0];
      push_request(make_request(pfmt_pkg::MODE_APPLY, near, 7'h7f, 7'h00, 7'h00, 1'b0));
      near = key_a;
      near[2][63] = ~near[2][63];
      push_request(make_request(pfmt_pkg::MODE_APPLY, near, 7'h12, 7'h00, 7'h00, 1'b0));
      // The wiped first slot is reused as a hole.
      push_request(make_request(pfmt_pkg::MODE_INSERT, key_c, 7'h00, 7'h2a, 7'h7f, 1'b0));
      push_request(make_request(pfmt_pkg::MODE_UNUSED, '1, 7'h7f, 7'h7f, 7'h7f, 1'b1));
      push_request(make_request(pfmt_pkg::MODE_APPLY, key_b, 7'h7f, 7'h00, 7'h00, 1'b0));
      for (int i = 0; i < 13; i++) begin
         push_request(make_request(pfmt_pkg::MODE_INSERT,
                                   (i == 12) ? '1 : random_key(), 7'h00,
                                   FLAG_W'($urandom_range(0, 127)),
                                   FLAG_W'($urandom_range(0, 127)),
                                   (i == 12) ? 1'b0 : i[0]));
      end
      // The end mark now sits on an active last slot, so this insert is dropped.
      push_request(make_request(pfmt_pkg::MODE_INSERT, '0, 7'h00, 7'h7f, 7'h7f, 1'b1));
      push_request(make_request(pfmt_pkg::MODE_APPLY, '1, 7'h00, 7'h00, 7'h00, 1'b0));
      // The last slot was wiped but keeps the end mark; the insert lands there.
      push_request(make_request(pfmt_pkg::MODE_INSERT, '0, 7'h00, 7'h7f, 7'h7f, 1'b1));
      push_request(make_request(pfmt_pkg::MODE_FORMAT, '0, 7'h00, 7'h00, 7'h00, 1'b0));

      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         no_idle = (seg % 5 == 2);
         case ($urandom_range(0, 2))
            0: insert_pct = 25;
            1: insert_pct = 45;
            default: insert_pct = 70;
         endcase
         for (int i = 0; i < SEGMENT_ITEMS; i++) push_request(random_request(insert_pct));
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      drain = 0;
      while (shadow.owed_results.size() > 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (30) @(posedge clock);
      if (shadow.owed_results.size() > 0) begin
         $error("%0d transactions never got a response", shadow.owed_results.size());
         shadow.mismatches++;
      end

      $display("Sent %0d transactions and checked %0d responses.", sent_count, rsp_count);
      $display("Applies with a match: %0d, inserts dropped on a full table: %0d, formats: %0d.",
               shadow.apply_hits, shadow.full_drops, shadow.formats);
      if (shadow.mismatches == 0) begin
         $display("pending_flag_modifier_table_tb passed");
      end else begin
         $display("pending_flag_modifier_table_tb failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/pfmt_pkg.sv
src/pfmt_ram.sv
src/pfmt_ctrl.sv
src/pending_flag_modifier_table.sv
dv/pending_flag_modifier_table_tb.sv
